### rtl/srug_pkg.sv
// Shared types, constants and helper functions for the seeded random UUID generator.
// No dependencies; every other file in rtl/ imports this package.
package srug_pkg;

    localparam int SEED_W = 64;
    localparam int BYTE_W = 8;
    localparam int INDEX_W = 4;
    localparam int ID_BYTES = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [SEED_W-1:0] GOLDEN_MIX = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [SEED_W-1:0] STAR_MULT = 64'd2685821657736338717;
    localparam logic [31:0] STAR_LO = STAR_MULT[31:0];
    localparam logic [31:0] STAR_HI = STAR_MULT[63:32];

    localparam logic [INDEX_W-1:0] LAST_ROUND = INDEX_W'(ID_BYTES - 1);
    localparam logic [INDEX_W-1:0] VERSION_BYTE = 4'd7;
    localparam logic [INDEX_W-1:0] VARIANT_BYTE = 4'd8;
    localparam logic [3:0] VERSION_NIBBLE = 4'h4;
    localparam logic [1:0] VARIANT_BITS = 2'b10;

    typedef struct packed {
        logic              valid;
        logic [SEED_W-1:0] value;
    } srug_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM
    } srug_state_t;

    // Three shift-xor steps of one xorshift64* round.
    function automatic logic [SEED_W-1:0] srug_xorshift(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] a;
        logic [SEED_W-1:0] b;
        a = v ^ (v >> 12);
        b = a ^ (a << 25);
        return b ^ (b >> 27);
    endfunction

    // Stamp version and variant bits into their identifier bytes.
    function automatic logic [BYTE_W-1:0] srug_fix_byte(input logic [BYTE_W-1:0] b,
                                                        input logic [INDEX_W-1:0] idx);
        logic [BYTE_W-1:0] r;
        r = b;
        if (idx == VERSION_BYTE)
        begin
            r = {VERSION_NIBBLE, b[3:0]};
        end
        else if (idx == VARIANT_BYTE)
        begin
            r = {VARIANT_BITS, b[5:0]};
        end
        return r;
    endfunction

endpackage

### rtl/srug_front.sv
// Front end: accepts seed requests and mixes in the golden-ratio constant.
// Depends on srug_pkg.
module srug_front
    import srug_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_valid,
    output logic              seed_ready,
    input  logic [SEED_W-1:0] seed,
    output srug_word_t        mixed,
    input  logic              mixed_ready
);

    srug_word_t stage_reg;
    srug_word_t stage_next;

    assign seed_ready = !stage_reg.valid || mixed_ready;
    assign mixed = stage_reg;

    always_comb
    begin
        stage_next = stage_reg;
        if (seed_ready)
        begin
            stage_next.valid = seed_valid;
            stage_next.value = seed ^ GOLDEN_MIX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

### rtl/srug_queue.sv
// Short FIFO between the front end and the round engine.
// Depends on srug_pkg.
module srug_queue
    import srug_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  srug_word_t push,
    output logic       push_ready,
    output srug_word_t head,
    input  logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [SEED_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign do_push = push.valid && push_ready;
    assign do_pop = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.value = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/srug_back.sv
// Round engine: runs sixteen xorshift64* rounds per mixed seed and drives result bytes.
// Depends on srug_pkg.
module srug_back
    import srug_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  srug_word_t         head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [INDEX_W-1:0] out_index,
    output logic               out_last
);

    srug_state_t state_reg;
    srug_state_t state_next;

    logic [SEED_W-1:0]  v_reg;
    logic [INDEX_W-1:0] round_reg;
    logic [SEED_W-1:0]  pp_lo_reg;
    logic [31:0]        pp_hl_reg;
    logic [31:0]        pp_lh_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_last_reg;

    logic [SEED_W-1:0]  shifted;
    logic [SEED_W-1:0]  product;
    logic [31:0]        cross_sum;
    logic               out_free;
    logic               sum_fire;
    logic               mul_en;
    logic               finishing;

    assign out_free = !out_valid_reg || out_ready;
    assign finishing = (round_reg == LAST_ROUND);

    assign shifted = srug_xorshift(v_reg);
    assign cross_sum = pp_hl_reg + pp_lh_reg;
    assign product = pp_lo_reg + {cross_sum, 32'h0};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    if (!finishing || head.valid)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop = 1'b0;
        mul_en = 1'b0;
        sum_fire = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop = head.valid;
            end
            ST_MUL:
            begin
                mul_en = 1'b1;
            end
            ST_SUM:
            begin
                sum_fire = out_free;
                pop = out_free && finishing && head.valid;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                round_reg <= '0;
            end
            else if (sum_fire)
            begin
                round_reg <= round_reg + 1'b1;
            end
            if (sum_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            v_reg <= head.value;
        end
        else if (sum_fire)
        begin
            v_reg <= product;
        end
        if (mul_en)
        begin
            pp_lo_reg <= 64'(shifted[31:0]) * 64'(STAR_LO);
            pp_hl_reg <= 32'(shifted[63:32] * STAR_LO);
            pp_lh_reg <= 32'(shifted[31:0] * STAR_HI);
        end
        if (sum_fire)
        begin
            out_byte_reg  <= srug_fix_byte(product[63:56], round_reg);
            out_index_reg <= round_reg;
            out_last_reg  <= finishing;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/seeded_random_uuid_generator.sv
// Each round splits its 64x64 multiply into registered 32x32 partial products, then sums them next cycle.
// A small seed queue lets new requests land while the round engine is busy.
// Reset: rst_n asynchronous, active low; clears all handshake and sequencing state.
module seeded_random_uuid_generator
    import srug_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Seed request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SEED_W-1:0]      s_axis_tdata,   // [63:0] seed
    // Identifier byte channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] byte_value, [11:8] byte_index, rest 0
    output logic                   m_axis_tlast    // last_byte
);

    srug_word_t         mixed;
    logic               mixed_ready;
    srug_word_t         head;
    logic               pop;
    logic [BYTE_W-1:0]  out_byte;
    logic [INDEX_W-1:0] out_index;

    // Mix the seed with the golden-ratio constant and hold it for the queue.
    srug_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_valid  (s_axis_tvalid),
        .seed_ready  (s_axis_tready),
        .seed        (s_axis_tdata),
        .mixed       (mixed),
        .mixed_ready (mixed_ready)
    );

    // Decouple request intake from the round engine.
    srug_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (mixed),
        .push_ready (mixed_ready),
        .head       (head),
        .pop        (pop)
    );

    // Advance sixteen rounds per seed and emit one byte per round.
    srug_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (out_byte),
        .out_index (out_index),
        .out_last  (m_axis_tlast)
    );

    // Pack result fields, zero-fill to a whole number of bytes.
    assign m_axis_tdata = {{(OUT_TDATA_W - BYTE_W - INDEX_W){1'b0}}, out_index, out_byte};

endmodule

### bench/seeded_random_uuid_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for seeded_random_uuid_generator: seed requests in, identifier bytes out.
// Predicts each 16-byte identifier on its own and scoreboards every byte request.
// Depends on srug_pkg and the generator top level under rtl/.
module seeded_random_uuid_generator_tb;
    import srug_pkg::*;

    localparam int HALF_NS = 6;
    localparam int RANDOM_SEEDS = 270;

    // Identifier derivation constants (xorshift64* with golden-ratio premix)
    localparam logic [63:0] PHI_MIX = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] STAR_FACTOR = 64'd2685821657736338717;
    localparam int BYTES_PER_ID = 16;
    localparam int VERSION_POS = 7;
    localparam int VARIANT_POS = 8;
    localparam logic [3:0] ID_VERSION = 4'h4;
    localparam logic [1:0] ID_VARIANT = 2'b10;

    // Receiver stall patterns
    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_EVERY_THIRD,
        SINK_BURSTY
    } sink_mode_t;

    typedef struct packed {
        logic [7:0] value;
        logic [3:0] index;
        logic       last;
    } id_byte_t;

    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic              drain_first;   // hold the request until every owed byte is out
    } seed_req_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SEED_W-1:0]      s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    seed_req_t  seed_backlog[$];   // seeds not yet accepted by the block
    id_byte_t   owed_bytes[$];     // identifier bytes predicted but not yet seen
    bit         seed_taken = 1'b0; // set by the monitor, consumed by the driver
    bit         flushing = 1'b0;   // keep the sink open during the closing quiet period
    int         mismatches = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         rx_tick = 0;
    sink_mode_t sink_mode = SINK_OPEN;

    seeded_random_uuid_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #(HALF_NS);
        clk = ~clk;
    end

    // Derive the sixteen identifier bytes for one seed and append them to the
    // owed list: premix with the golden ratio, then one xorshift64* round per
    // byte, taking the top byte of each round. Stamp version and variant last.
    task automatic derive_identifier(input logic [SEED_W-1:0] seed);
        logic [63:0] w;
        id_byte_t    b;
        w = seed ^ PHI_MIX;
        for (int i = 0; i < BYTES_PER_ID; i++)
        begin
            w = w ^ (w >> 12);
            w = w ^ (w << 25);
            w = w ^ (w >> 27);
            w = w * STAR_FACTOR;
            b.value = w[63:56];
            if (i == VERSION_POS)
            begin
                b.value = {ID_VERSION, b.value[3:0]};
            end
            else if (i == VARIANT_POS)
            begin
                b.value = {ID_VARIANT, b.value[5:0]};
            end
            b.index = 4'(i);
            b.last = (i == BYTES_PER_ID - 1);
            owed_bytes.push_back(b);
        end
    endtask

    task automatic queue_seed(input logic [SEED_W-1:0] seed, input logic drain_first);
        seed_req_t r;
        r.seed = seed;
        r.drain_first = drain_first;
        seed_backlog.push_back(r);
    endtask

    // Monitor: sample both channels at the rising edge. Predict on every
    // accepted seed first, then check any byte accepted on the same edge.
    always @(posedge clk)
    begin : handshake_monitor
        id_byte_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                derive_identifier(s_axis_tdata);
                seed_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_bytes.size() == 0)
                begin
                    $error("unexpected byte request: tdata %0h tlast %0b",
                           m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (m_axis_tdata[7:0] !== want.value)
                    begin
                        $error("byte_value: expected %0h, got %0h",
                               want.value, m_axis_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[11:8] !== want.index)
                    begin
                        $error("byte_index: expected %0d, got %0d",
                               want.index, m_axis_tdata[11:8]);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last_byte: expected %0b, got %0b", want.last, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:12] !== '0)
                    begin
                        $error("tdata padding: expected 0, got %0h",
                               m_axis_tdata[OUT_TDATA_W-1:12]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Driver: advance at the falling edge. Once raised, tvalid holds until the
    // request is taken; only then pick the next seed, a gap, or a drain pause.
    always @(negedge clk)
    begin : seed_driver
        bit took;
        if (rst_n)
        begin
            took = seed_taken;
            seed_taken = 1'b0;
            if (took)
            begin
                void'(seed_backlog.pop_front());
            end
            if (!s_axis_tvalid || took)
            begin
                if (seed_backlog.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else if (seed_backlog[0].drain_first && owed_bytes.size() != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= seed_backlog[0].seed;
                    // Close the burst on its last request and draw the next gap;
                    // a third of the gaps are zero so bursts run back to back.
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 10);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
        end
    end

    // Sink: step through randomly drawn stall patterns so gaps land on every phase
    // of the round engine, with fully open stretches in between.
    always @(negedge clk)
    begin : byte_sink
        if (rst_n)
        begin
            if (rx_tick % 256 == 0)
            begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
            end
            rx_tick++;
            if (flushing)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                case (sink_mode)
                    SINK_OPEN:        m_axis_tready <= 1'b1;
                    SINK_RANDOM:      m_axis_tready <= ($urandom_range(0, 3) != 0);
                    SINK_EVERY_THIRD: m_axis_tready <= (rx_tick % 3 == 0);
                    default:          m_axis_tready <= (rx_tick % 40 < 16);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [SEED_W-1:0] seed;
        // Directed seeds: extremes, alternating patterns, and the seed that
        // cancels the golden-ratio premix and leaves a zero working value.
        queue_seed(64'h0000_0000_0000_0000, 1'b0);
        queue_seed(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_seed(64'h0000_0000_0000_0001, 1'b0);
        queue_seed(64'h8000_0000_0000_0000, 1'b0);
        queue_seed(PHI_MIX, 1'b0);
        queue_seed(~PHI_MIX, 1'b0);
        queue_seed(PHI_MIX ^ 64'h1, 1'b0);
        queue_seed(64'h5555_5555_5555_5555, 1'b0);
        queue_seed(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_seed(64'h0000_0000_FFFF_FFFF, 1'b0);
        queue_seed(64'hFFFF_FFFF_0000_0000, 1'b0);
        queue_seed(64'h0123_4567_89AB_CDEF, 1'b0);
        queue_seed(64'hFEDC_BA98_7654_3210, 1'b0);

        // Random seeds; hold the sender twice until the block has drained.
        for (int i = 0; i < RANDOM_SEEDS; i++)
        begin
            case ($urandom_range(0, 7))
                0:       seed = 64'($urandom_range(0, 255));
                1:       seed = PHI_MIX ^ 64'($urandom_range(0, 255));
                2:       seed = 64'h1 << $urandom_range(0, 63);
                3:       seed = ~(64'h1 << $urandom_range(0, 63));
                default: seed = {$urandom, $urandom};
            endcase
            queue_seed(seed, (i == 0) || (i == RANDOM_SEEDS / 2));
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (seed_backlog.size() != 0 || owed_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        // Open the sink and watch for stray bytes past the last identifier.
        flushing = 1'b1;
        repeat (80) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run, all stalls included.
    initial
    begin : watchdog
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
